// ===== hdl/cordic_atan2_defines.svh =====
// cordic_atan2_defines.svh: assertion macros used by the checker file
// no dependencies; include guard below
`ifndef CORDIC_ATAN2_DEFINES_SVH
`define CORDIC_ATAN2_DEFINES_SVH

// concurrent check, masked while reset is high
`define CA_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// concurrent check that also runs across reset
`define CA_ASSERT_RST(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ===== hdl/catan2_pkg.sv =====
// catan2_pkg: widths, stage payload type and arctangent table for cordic_atan2
// no dependencies
`timescale 1ns / 1ps

package catan2_pkg;

  localparam int ITERATIONS = 16;
  localparam int DATA_WIDTH = 32;

  // port widths fixed by the item fields
  localparam int COORD_W  = 32;
  localparam int ANGLE_W  = 23;
  localparam int IN_W     = 2 * COORD_W;
  localparam int OUT_W    = ((ANGLE_W + 7) / 8) * 8;

  // internal x/y carry two guard bits
  localparam int XY_W = DATA_WIDTH + 2;

  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q20 = 23'sd1647099;

  typedef struct packed {
    logic signed [XY_W-1:0]    x;
    logic signed [XY_W-1:0]    y;
    logic signed [ANGLE_W-1:0] theta;
  } vec_t;

  // atan(2^-i) in q20
  function automatic logic signed [ANGLE_W-1:0] atan_entry(input int idx);
    logic signed [ANGLE_W-1:0] r;
    unique case (idx)
      0:       r = 23'sd823549;
      1:       r = 23'sd486169;
      2:       r = 23'sd256878;
      3:       r = 23'sd130395;
      4:       r = 23'sd65450;
      5:       r = 23'sd32757;
      6:       r = 23'sd16382;
      7:       r = 23'sd8191;
      8:       r = 23'sd4095;
      9:       r = 23'sd2047;
      10:      r = 23'sd1023;
      11:      r = 23'sd511;
      12:      r = 23'sd255;
      13:      r = 23'sd127;
      14:      r = 23'sd63;
      15:      r = 23'sd31;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/catan2_prerot.sv =====
// catan2_prerot: input stage, sign extension and quarter-turn pre-rotation
// depends on catan2_pkg
`timescale 1ns / 1ps

module catan2_prerot (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [catan2_pkg::DATA_WIDTH-1:0] y_raw,
  input  logic [catan2_pkg::DATA_WIDTH-1:0] x_raw,
  output logic                      out_valid,
  input  logic                      out_ready,
  output catan2_pkg::vec_t          out_vec
);
  import catan2_pkg::*;

  logic signed [XY_W-1:0] y_ext;
  logic signed [XY_W-1:0] x_ext;
  vec_t                   vec_next;

  assign y_ext = XY_W'(signed'(y_raw));
  assign x_ext = XY_W'(signed'(x_raw));

  always_comb begin
    vec_next.x     = x_ext;
    vec_next.y     = y_ext;
    vec_next.theta = '0;
    if (x_ext[XY_W-1]) begin
      if (!y_ext[XY_W-1]) begin
        vec_next.theta = HALF_PI_Q20;
        vec_next.x     = y_ext;
        vec_next.y     = -x_ext;
      end else begin
        vec_next.theta = -HALF_PI_Q20;
        vec_next.x     = -y_ext;
        vec_next.y     = x_ext;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_vec <= vec_next;
    end
  end

endmodule

// ===== hdl/catan2_rotator.sv =====
// catan2_rotator: chain of registered micro-rotation stages, one per table entry
// depends on catan2_pkg
`timescale 1ns / 1ps

module catan2_rotator (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  catan2_pkg::vec_t in_vec,
  output logic             out_valid,
  input  logic             out_ready,
  output catan2_pkg::vec_t out_vec
);
  import catan2_pkg::*;

  logic [ITERATIONS-1:0] valid;
  logic [ITERATIONS-1:0] rdy;
  vec_t                  vec [ITERATIONS];

  // stage k may load when empty or when stage k+1 takes its item
  assign rdy[ITERATIONS-1] = !valid[ITERATIONS-1] || out_ready;

  genvar k;
  generate
    for (k = 0; k < ITERATIONS; k++) begin : g_stage
      logic src_valid;
      vec_t src;
      vec_t nxt;

      if (k == 0) begin : g_first
        assign src_valid = in_valid;
        assign src       = in_vec;
      end else begin : g_rest
        assign src_valid = valid[k-1];
        assign src       = vec[k-1];
      end

      if (k < ITERATIONS - 1) begin : g_rdy
        assign rdy[k] = !valid[k] || rdy[k+1];
      end

      // zero y counts as non-negative
      always_comb begin
        if (src.y[XY_W-1]) begin
          nxt.x     = src.x - (src.y >>> k);
          nxt.y     = src.y + (src.x >>> k);
          nxt.theta = src.theta - atan_entry(k);
        end else begin
          nxt.x     = src.x + (src.y >>> k);
          nxt.y     = src.y - (src.x >>> k);
          nxt.theta = src.theta + atan_entry(k);
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          valid[k] <= 1'b0;
        end else if (rdy[k]) begin
          valid[k] <= src_valid;
        end
        if (rdy[k] && src_valid) begin
          vec[k] <= nxt;
        end
      end
    end
  endgenerate

  assign in_ready  = rdy[0];
  assign out_valid = valid[ITERATIONS-1];
  assign out_vec   = vec[ITERATIONS-1];

endmodule

// ===== hdl/cordic_atan2.sv =====
// cordic_atan2: four-quadrant arctangent, as a q20 angle, of a point by pipelined cordic vectoring
// depends on catan2_pkg, catan2_prerot, catan2_rotator
//
//  channel | dir | width | contents (lsb first)
//  --------+-----+-------+--------------------------------------
//  s_*     | in  | 64    | y_coord[31:0], x_coord[63:32]
//  m_*     | out | 24    | angle[22:0], zero pad [23]
//
// one item per clock sustained while m_tready stays high; each item passes the
// pre-rotation register and then one register per micro-rotation stage
// every stage holds a valid bit and loads when empty or when its successor
// loads, so bubbles are squeezed out and a stalled output holds its item
// while upstream stages keep filling
// rst is synchronous and clears only the valid bits
`timescale 1ns / 1ps

module cordic_atan2 (
  input  logic                         clk,
  input  logic                         rst,
  // item in: y_coord [31:0], x_coord [63:32]
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [catan2_pkg::IN_W-1:0]  s_tdata,
  // item out: angle [22:0], zero [23]
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [catan2_pkg::OUT_W-1:0] m_tdata
);
  import catan2_pkg::*;

  // handoff between pre-rotation and rotation chain
  logic pre_valid;
  logic pre_ready;
  vec_t pre_vec;
  vec_t fin_vec;

  // only the low DATA_WIDTH bits of each coordinate are used
  catan2_prerot u_prerot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .y_raw     (s_tdata[DATA_WIDTH-1:0]),
    .x_raw     (s_tdata[COORD_W +: DATA_WIDTH]),
    .out_valid (pre_valid),
    .out_ready (pre_ready),
    .out_vec   (pre_vec)
  );

  // last rotator stage doubles as the output register
  catan2_rotator u_rotator (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pre_valid),
    .in_ready  (pre_ready),
    .in_vec    (pre_vec),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_vec   (fin_vec)
  );

  // angle goes out as-is, upper pad bits zero
  assign m_tdata = {{(OUT_W - ANGLE_W){1'b0}}, fin_vec.theta};

endmodule

// ===== hdl/catan2_checker.sv =====
// catan2_checker: port-level checks for cordic_atan2, bound to the top level
// depends on catan2_pkg, cordic_atan2_defines.svh
`timescale 1ns / 1ps
`include "cordic_atan2_defines.svh"

module catan2_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic [catan2_pkg::IN_W-1:0]  s_tdata,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [catan2_pkg::OUT_W-1:0] m_tdata
);
  import catan2_pkg::*;

  logic signed [ANGLE_W-1:0] ang;
  logic                      ang_ok;

  assign ang     = m_tdata[ANGLE_W-1:0];
  assign ang_ok  = (ang <= 23'sd3475022) && (ang >= -23'sd3475022) &&
                   (m_tdata[OUT_W-1:ANGLE_W] == '0);

  // the pipeline only refuses input when its output is blocked
  `CA_ASSERT(a_stall_backs_up, clk, rst, !s_tready |-> (m_tvalid && !m_tready), "input refused without output stall")

  // result bounded by half pi plus the table sum, pad bits clear
  `CA_ASSERT(a_angle_range, clk, rst, m_tvalid |-> ang_ok, "angle out of range")

  // a waiting result is neither dropped nor changed
  `CA_ASSERT(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result dropped or changed")

  // reset empties the pipeline, nothing comes out the cycle after
  `CA_ASSERT_RST(a_reset_empty, clk, rst |=> !m_tvalid, "result present right after reset")

endmodule

bind cordic_atan2 catan2_checker u_catan2_checker (.*);
